// ===== src/tesp_pkg.sv =====
// Shared types, constants and the terminal-type reply table for the Telnet stream parser.
package tesp_pkg;

  // Telnet command bytes.
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_EOR  = 8'd239;

  // Options that the block agrees to.
  localparam logic [7:0] OPT_BIN_MODE  = 8'd0;
  localparam logic [7:0] OPT_TERM_TYPE = 8'd24;
  localparam logic [7:0] OPT_EOR       = 8'd25;

  // Result kinds as they appear on the result port.
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_EOR  = 2'd1;
  localparam logic [1:0] KIND_TX   = 2'd2;

  // Default depth of the command queue between parser and expander.
  localparam int CMD_DEPTH = 4;

  // Length of the terminal-type reply, and the width of the index that walks it.
  localparam int          TTYPE_LEN = 16;
  localparam int          IDX_W     = $clog2(TTYPE_LEN);
  localparam logic [IDX_W-1:0] IDX_TTYPE_LAST = IDX_W'(TTYPE_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_REPLY_LAST = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_SINGLE     = IDX_W'(0);

  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_IAC     = 3'd1,
    ST_VERB    = 3'd2,
    ST_SUBOPT  = 3'd3,
    ST_SUBDATA = 3'd4,
    ST_SUBIAC  = 3'd5
  } pstate_t;

  typedef enum logic [1:0] {
    VERB_WILL = 2'd0,
    VERB_WONT = 2'd1,
    VERB_DO   = 2'd2,
    VERB_DONT = 2'd3
  } verb_t;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_EOR   = 2'd1,
    CMD_REPLY = 2'd2,
    CMD_TTYPE = 2'd3
  } cmd_kind_t;

  // One classified command: a data byte, an end-of-record marker,
  // a three-byte negotiation reply or the terminal-type reply.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;    // data byte, or option byte of a reply
    logic [7:0] answer;  // verb byte of a reply
  } cmd_t;

  // Bytes of the fixed terminal-type reply: IAC SB 24 IS, model name, IAC SE.
  function automatic logic [7:0] ttype_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'hFF;
      4'd1:    b = 8'hFA;
      4'd2:    b = 8'h18;
      4'd3:    b = 8'h00;
      4'd4:    b = 8'h49;
      4'd5:    b = 8'h42;
      4'd6:    b = 8'h4D;
      4'd7:    b = 8'h2D;
      4'd8:    b = 8'h33;
      4'd9:    b = 8'h31;
      4'd10:   b = 8'h37;
      4'd11:   b = 8'h39;
      4'd12:   b = 8'h2D;
      4'd13:   b = 8'h32;
      4'd14:   b = 8'hFF;
      4'd15:   b = 8'hF0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic option_ok(input logic [7:0] opt);
    return (opt == OPT_BIN_MODE) || (opt == OPT_EOR) || (opt == OPT_TERM_TYPE);
  endfunction

endpackage

// ===== src/tesp_front.sv =====
// Parser front end: runs the Telnet state machine and issues one command per producing byte.
module tesp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_en,
  input  logic [7:0]        rx_byte,
  output logic              cmd_push,
  output tesp_pkg::cmd_t    cmd
);
  import tesp_pkg::*;

  pstate_t    state_r, state_nxt;
  verb_t      verb_r, verb_nxt;
  logic [7:0] subopt_r, subopt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_DATA;
      verb_r   <= VERB_WILL;
      subopt_r <= 8'd0;
    end else begin
      state_r  <= state_nxt;
      verb_r   <= verb_nxt;
      subopt_r <= subopt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    verb_nxt   = verb_r;
    subopt_nxt = subopt_r;
    cmd_push   = 1'b0;
    cmd.kind   = CMD_DATA;
    cmd.data   = rx_byte;
    cmd.answer = B_IAC;
    if (byte_en) begin
      case (state_r)
        ST_IAC: begin
          state_nxt = ST_DATA;
          if (rx_byte == B_IAC) begin
            cmd_push = 1'b1;
          end else if (rx_byte == B_EOR) begin
            cmd_push = 1'b1;
            cmd.kind = CMD_EOR;
            cmd.data = 8'd0;
          end else if (rx_byte == B_SB) begin
            state_nxt = ST_SUBOPT;
          end else if (rx_byte == B_WILL || rx_byte == B_WONT ||
                       rx_byte == B_DO || rx_byte == B_DONT) begin
            verb_nxt  = verb_t'(2'(rx_byte - B_WILL));
            state_nxt = ST_VERB;
          end
        end
        ST_VERB: begin
          cmd_push  = 1'b1;
          cmd.kind  = CMD_REPLY;
          state_nxt = ST_DATA;
          case (verb_r)
            VERB_WILL: cmd.answer = option_ok(rx_byte) ? B_DO : B_DONT;
            VERB_WONT: cmd.answer = B_DONT;
            VERB_DO:   cmd.answer = option_ok(rx_byte) ? B_WILL : B_WONT;
            default:   cmd.answer = B_WONT;
          endcase
        end
        ST_SUBOPT: begin
          subopt_nxt = rx_byte;
          state_nxt  = ST_SUBDATA;
        end
        ST_SUBDATA: begin
          if (rx_byte == B_IAC) begin
            state_nxt = ST_SUBIAC;
          end
        end
        ST_SUBIAC: begin
          if (rx_byte == B_SE) begin
            state_nxt = ST_DATA;
            if (subopt_r == OPT_TERM_TYPE) begin
              cmd_push = 1'b1;
              cmd.kind = CMD_TTYPE;
            end
          end else begin
            state_nxt = ST_SUBDATA;
          end
        end
        default: begin
          // Data state; the unused codes behave the same way.
          if (rx_byte == B_IAC) begin
            state_nxt = ST_IAC;
          end else begin
            cmd_push  = 1'b1;
            state_nxt = ST_DATA;
          end
        end
      endcase
    end
  end

endmodule

// ===== src/tesp_cmd_fifo.sv =====
// Short command queue between the parser and the result expander.
module tesp_cmd_fifo #(
  parameter int DEPTH = tesp_pkg::CMD_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  tesp_pkg::cmd_t    wr_cmd,
  output logic              full,
  input  logic              rd_en,
  output tesp_pkg::cmd_t    rd_cmd,
  output logic              empty
);
  import tesp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t            mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign rd_cmd = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

  // The occupancy never goes beyond the depth.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH))
    else $error("command queue occupancy beyond depth");

  // A read only ever takes an entry that is there.
  assert property (@(posedge clk) disable iff (!rst_n) rd_en |-> !empty)
    else $error("command queue read while empty");

  // A write when full would overwrite the oldest command.
  assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> (!full || rd_en))
    else $error("command queue written while full");

endmodule

// ===== src/tesp_back.sv =====
// Result expander: turns each queued command into its result bytes behind an output register.
module tesp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tesp_pkg::cmd_t    cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_byte,
  output logic              out_run_last
);
  import tesp_pkg::*;

  logic              valid_r, valid_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              adv;
  logic [IDX_W-1:0]  idx_last;

  always_comb begin
    case (cmd.kind)
      CMD_REPLY: idx_last = IDX_REPLY_LAST;
      CMD_TTYPE: idx_last = IDX_TTYPE_LAST;
      default:   idx_last = IDX_SINGLE;
    endcase
  end

  assign adv = !valid_r || out_pop;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    kind_nxt  = kind_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    cmd_pop   = 1'b0;
    if (adv) begin
      valid_nxt = !cmd_empty;
      if (!cmd_empty) begin
        last_nxt = (idx_r == idx_last);
        if (idx_r == idx_last) begin
          cmd_pop = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
        case (cmd.kind)
          CMD_DATA: begin
            kind_nxt = KIND_DATA;
            byte_nxt = cmd.data;
          end
          CMD_EOR: begin
            kind_nxt = KIND_EOR;
            byte_nxt = 8'd0;
          end
          CMD_REPLY: begin
            kind_nxt = KIND_TX;
            case (idx_r)
              4'd0:    byte_nxt = B_IAC;
              4'd1:    byte_nxt = cmd.answer;
              default: byte_nxt = cmd.data;
            endcase
          end
          default: begin
            kind_nxt = KIND_TX;
            byte_nxt = ttype_byte(idx_r);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_empty    = !valid_r;
  assign out_kind     = kind_r;
  assign out_byte     = byte_r;
  assign out_run_last = last_r;

  // While a command is half expanded it stays at the head of the queue.
  assert property (@(posedge clk) disable iff (!rst_n) (idx_r != '0) |-> !cmd_empty)
    else $error("expansion in progress with no command queued");

  // An end-of-record marker always carries a zero byte and closes its run.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (valid_r && kind_r == KIND_EOR) |-> (byte_r == 8'd0 && last_r))
    else $error("malformed end-of-record result");

  // Popping a command always coincides with the last result of its run.
  assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |=> (valid_r && last_r))
    else $error("command retired without its final result");

endmodule

// ===== src/telnet_eor_stream_parser_top.sv =====
// Top level of the Telnet receive parser for a block-mode record stream.
//
// Input channel: one received link byte per transaction on in_rx_byte, taken at
// a rising edge with in_push high and in_full low. Result channel: the oldest
// result sits on out_kind, out_byte and out_run_last while out_empty is low and
// is taken at a rising edge with out_pop high. out_kind is 0 for a record data
// byte, 1 for end of record and 2 for a byte to transmit to the host;
// out_run_last marks the final result caused by one input byte.
//
// The first result of a byte is written into the command queue and then into
// the output register. Throughput: one byte per cycle while in_full is low,
// set by the parser state update. Results leave the output register at one
// per cycle while out_pop is high; a negotiation reply is three results and
// the terminal-type reply sixteen. The command queue between the two halves
// absorbs such bursts, and in_full rises only when that queue is full.
//
// Reset (rst_n low at a clock edge) returns the parser to the data state,
// clears the pending verb and option byte and empties the queue and output.
// When the receiver stops popping, the current result holds on the ports and
// input transactions continue until the command queue fills.
module telnet_eor_stream_parser_top #(
  parameter int CMD_DEPTH = tesp_pkg::CMD_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_rx_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_run_last
);
  import tesp_pkg::*;

  logic  byte_en;
  logic  cmd_push;
  cmd_t  cmd_in;
  cmd_t  cmd_head;
  logic  cmd_full;
  logic  cmd_empty;
  logic  cmd_pop;

  // A byte is taken whenever the queue has room, whether or not it produces
  // a command; bytes that produce nothing only update the parser state.
  assign in_full = cmd_full;
  assign byte_en = in_push && !cmd_full;

  tesp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_en  (byte_en),
    .rx_byte  (in_rx_byte),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  tesp_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_cmd (cmd_in),
    .full   (cmd_full),
    .rd_en  (cmd_pop),
    .rd_cmd (cmd_head),
    .empty  (cmd_empty)
  );

  tesp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd_head),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule
